>>> hw/rtl/dmc_pkg.sv
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared types, register codes and the bit period table of the delta
// modulation sound channel.
// ----------------------------------------------------------------------------
`default_nettype none

package dmc_pkg;

  localparam int unsigned InTdataW  = 24;
  localparam int unsigned OutTdataW = 32;

  localparam logic [15:0] AddrBase = 16'hC000;
  localparam logic [15:0] AddrTop  = 16'hFFFF;
  localparam logic [15:0] AddrWrap = 16'h8000;
  localparam logic [5:0]  LevelMax = 6'h3F;

  // register offsets from 0x4000
  typedef enum logic [4:0] {
    RegMode   = 5'h10,
    RegLevel  = 5'h11,
    RegStart  = 5'h12,
    RegLength = 5'h13,
    RegEnable = 5'h15
  } reg_idx_e;

  typedef enum logic {
    CmdWrite = 1'b0,
    CmdTick  = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e       command;
    logic [4:0] reg_index;
    logic [7:0] write_data;
    logic [7:0] fetch_data;
  } dmc_item_t;

  typedef struct packed {
    logic [6:0]  dac_level;
    logic        channel_active;
    logic        irq_flag;
    logic [15:0] fetch_address;
    logic        fetch_taken;
  } dmc_result_t;

  function automatic logic [8:0] period_lookup(input logic [3:0] sel);
    logic [8:0] p;
    unique case (sel)
      4'd0:    p = 9'd428;
      4'd1:    p = 9'd380;
      4'd2:    p = 9'd340;
      4'd3:    p = 9'd320;
      4'd4:    p = 9'd286;
      4'd5:    p = 9'd254;
      4'd6:    p = 9'd226;
      4'd7:    p = 9'd214;
      4'd8:    p = 9'd190;
      4'd9:    p = 9'd160;
      4'd10:   p = 9'd142;
      4'd11:   p = 9'd128;
      4'd12:   p = 9'd106;
      4'd13:   p = 9'd84;
      4'd14:   p = 9'd72;
      default: p = 9'd54;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/dmc_channel.sv
// ----------------------------------------------------------------------------
// dmc_channel
// Channel state and its single-pass update for one request: register write
// or one clock tick. Gives the result that follows the request.
// ----------------------------------------------------------------------------
`default_nettype none

module dmc_channel import dmc_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         step_i,
  input  wire dmc_item_t item_i,
  output dmc_result_t result_o
);

  logic        active_q, active_d;
  logic        irq_q, irq_d;
  logic [1:0]  mode_q, mode_d;
  logic [8:0]  period_q, period_d;
  logic [5:0]  level_q, level_d;
  logic        lsb_q, lsb_d;
  logic [15:0] cur_addr_q, cur_addr_d;
  logic [15:0] start_addr_q, start_addr_d;
  logic [11:0] bytes_left_q, bytes_left_d;
  logic [11:0] start_len_q, start_len_d;
  logic [7:0]  shift_q, shift_d;
  logic [3:0]  bits_left_q, bits_left_d;
  logic [8:0]  rate_q, rate_d;
  logic        taken;

  always_comb begin
    logic [8:0] rate_inc;
    logic       stop;
    active_d     = active_q;
    irq_d        = irq_q;
    mode_d       = mode_q;
    period_d     = period_q;
    level_d      = level_q;
    lsb_d        = lsb_q;
    cur_addr_d   = cur_addr_q;
    start_addr_d = start_addr_q;
    bytes_left_d = bytes_left_q;
    start_len_d  = start_len_q;
    shift_d      = shift_q;
    bits_left_d  = bits_left_q;
    rate_d       = rate_q;
    taken        = 1'b0;
    stop         = 1'b0;
    rate_inc     = rate_q + 9'd1;

    if (item_i.command == CmdWrite) begin
      unique case (item_i.reg_index)
        RegMode: begin
          mode_d   = item_i.write_data[7:6];
          period_d = period_lookup(item_i.write_data[3:0]);
          if (!item_i.write_data[7]) irq_d = 1'b0;
        end
        RegLevel: begin
          lsb_d   = item_i.write_data[0];
          level_d = item_i.write_data[6:1];
        end
        RegStart: begin
          start_addr_d = AddrBase | {2'b00, item_i.write_data, 6'b0};
        end
        RegLength: begin
          start_len_d = {item_i.write_data, 4'b0001};
        end
        RegEnable: begin
          if (item_i.write_data[4]) begin
            if (!active_q) begin
              cur_addr_d   = start_addr_q;
              bytes_left_d = start_len_q;
              bits_left_d  = 4'd0;
            end
            active_d = 1'b1;
          end else begin
            active_d = 1'b0;
          end
          irq_d = 1'b0;
        end
        default: begin
        end
      endcase
    end else if (active_q) begin
      if (rate_inc <= period_q) begin
        rate_d = rate_inc;
      end else begin
        rate_d = rate_inc - period_q;
        if (bits_left_q == 4'd0) begin
          // refill; reload on loop, stop otherwise
          if (bytes_left_q == 12'd0) begin
            if (mode_q[0]) begin
              cur_addr_d   = start_addr_q;
              bytes_left_d = start_len_q;
            end else begin
              stop     = 1'b1;
              active_d = 1'b0;
              if (mode_q == 2'd2) irq_d = 1'b1;
            end
          end
          if (!stop) begin
            taken       = 1'b1;
            bits_left_d = 4'd8;
            shift_d     = item_i.fetch_data;
            cur_addr_d  = (cur_addr_d == AddrTop) ? AddrWrap : cur_addr_d + 16'd1;
            if (bytes_left_d != 12'd0) bytes_left_d = bytes_left_d - 12'd1;
          end
        end
        if (!stop) begin
          if (shift_d[0]) begin
            if (level_q != LevelMax) level_d = level_q + 6'd1;
          end else begin
            if (level_q != 6'd0) level_d = level_q - 6'd1;
          end
          bits_left_d = bits_left_d - 4'd1;
          shift_d     = {1'b0, shift_d[7:1]};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      irq_q        <= 1'b0;
      mode_q       <= 2'd0;
      period_q     <= period_lookup(4'd0);
      level_q      <= 6'd0;
      lsb_q        <= 1'b0;
      cur_addr_q   <= 16'd0;
      start_addr_q <= 16'd0;
      bytes_left_q <= 12'd0;
      start_len_q  <= 12'd0;
      shift_q      <= 8'd0;
      bits_left_q  <= 4'd0;
      rate_q       <= 9'd0;
    end else if (step_i) begin
      active_q     <= active_d;
      irq_q        <= irq_d;
      mode_q       <= mode_d;
      period_q     <= period_d;
      level_q      <= level_d;
      lsb_q        <= lsb_d;
      cur_addr_q   <= cur_addr_d;
      start_addr_q <= start_addr_d;
      bytes_left_q <= bytes_left_d;
      start_len_q  <= start_len_d;
      shift_q      <= shift_d;
      bits_left_q  <= bits_left_d;
      rate_q       <= rate_d;
    end
  end

  // level*2+lsb-64 in 7 bits is the same word with the top bit flipped
  assign result_o.dac_level      = {~level_d[5], level_d[4:0], lsb_d};
  assign result_o.channel_active = active_d;
  assign result_o.irq_flag       = irq_d;
  assign result_o.fetch_address  = cur_addr_d;
  assign result_o.fetch_taken    = taken;

endmodule

`default_nettype wire

>>> hw/rtl/delta_modulation_channel_core.sv
// ----------------------------------------------------------------------------
// delta_modulation_channel_core
// Delta modulation sound channel: register writes and clock ticks in, one
// status result per request out.
// ----------------------------------------------------------------------------
// Usage: each request on the slave stream is a register write (tuser 0) or
// one CPU clock tick (tuser 1). Every request gives exactly one result on the
// master stream: DAC level minus 64, active and irq flags, the address of
// the next refill and a flag telling whether this tick consumed fetch_data.
// The caller drives fetch_data with the byte at the last fetch address seen.
// Registers: the input register is loaded at the edge that accepts a request,
// and the result register, which drives tvalid, loads from the state update
// behind it. Throughput: one request per cycle while the receiver takes
// results, set by the single-pass state update between the two registers.
// Reset clears all channel state; the period goes to table entry 0.
// When the receiver stalls, the result register holds and one further
// request is taken into the input register; after that tready drops until
// the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module delta_modulation_channel_core import dmc_pkg::*; (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [4:0] reg_index, [12:5] write_data, [20:13] fetch_data, [23:21] zero
  input  wire  [InTdataW-1:0]   s_axis_tdata_i,
  // [0] command
  input  wire                   s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  wire                   m_axis_tready_i,
  // [6:0] dac_level, [7] channel_active, [8] irq_flag, [24:9] fetch_address,
  // [25] fetch_taken, [31:26] zero
  output logic [OutTdataW-1:0]  m_axis_tdata_o
);

  logic        in_valid_q;
  dmc_item_t   in_item_q;
  logic        out_valid_q;
  dmc_result_t out_res_q;
  dmc_result_t res;
  logic        advance;
  logic        in_take;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.command    <= cmd_e'(s_axis_tuser_i);
      in_item_q.reg_index  <= s_axis_tdata_i[4:0];
      in_item_q.write_data <= s_axis_tdata_i[12:5];
      in_item_q.fetch_data <= s_axis_tdata_i[20:13];
    end
    if (advance) begin
      out_res_q <= res;
    end
  end

  dmc_channel u_channel (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_item_q),
    .result_o (res)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_res_q.fetch_taken, out_res_q.fetch_address,
                            out_res_q.irq_flag, out_res_q.channel_active,
                            out_res_q.dac_level};

`ifndef SYNTHESIS
  // a consumed byte never comes with the channel stopped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[25]) |-> m_axis_tdata_o[7])
    else $error("fetch taken while channel inactive");

  // a pending request moves on whenever the result slot frees up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && m_axis_tready_i) |=> m_axis_tvalid_o)
    else $error("pending request not forwarded");

  // backpressure only with a request already held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_valid_q && out_valid_q))
    else $error("tready low without held request");

  // a stalled result is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(m_axis_tdata_o))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
